// ===== hdl/mm1h_pkg.sv =====
// Shared types and constants for the MurmurHash1 stream core.
// Used by mm1h_ctrl, mm1h_datapath and murmur1_hash_stream_core; no dependencies.
package mm1h_pkg;

    // Hash constants of the 32-bit MurmurHash1 algorithm.
    localparam logic [31:0] MURMUR_MULT   = 32'hc6a4a793;
    localparam int unsigned MIX_SHIFT     = 16;
    localparam int unsigned FINAL_SHIFT_A = 10;
    localparam int unsigned FINAL_SHIFT_B = 17;

    // Width of the byte count field and the count of a full word.
    localparam int unsigned  BCNT_W    = 3;
    localparam logic [2:0]   BCNT_FULL = 3'd4;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_MIX,
        OP_XS16,
        OP_FMUL,
        OP_XS10,
        OP_FINISH
    } op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_SHIFT,
        ST_FMUL_A,
        ST_FMIX_A,
        ST_FMUL_B,
        ST_FMIX_B
    } state_t;

    // Command from controller to datapath.
    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic word_used;
    } dp_status_t;

    // Mask that keeps the valid low bytes of a word; counts of four and up keep all.
    function automatic logic [31:0] byte_mask(input logic [BCNT_W-1:0] cnt);
        logic [31:0] mask;
        begin
            unique case (cnt)
                3'd0:    mask = 32'h0000_0000;
                3'd1:    mask = 32'h0000_00ff;
                3'd2:    mask = 32'h0000_ffff;
                3'd3:    mask = 32'h00ff_ffff;
                default: mask = 32'hffff_ffff;
            endcase
            return mask;
        end
    endfunction

endpackage

// ===== hdl/murmur1_hash_stream_core.sv =====
// MurmurHash1 (32-bit, zero seed) over a stream of little-endian words.
// A beat runs through the shared constant multiplier and the xor-shift that
// follows each multiply; a first beat also multiplies in the total length, and
// a new beat is taken only in idle. A last beat then runs the final mix, whose
// finishing step waits while an earlier hash is unread. Reset: aresetn, synchronous,
// active low; it idles the controller, clears the running hash, drops m_valid.
module murmur1_hash_stream_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_first,
    input  logic        s_last,
    input  logic [31:0] s_total_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash
);
    import mm1h_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    mm1h_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_first (s_first),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    mm1h_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_word         (s_word),
        .s_byte_count   (s_byte_count),
        .s_first        (s_first),
        .s_last         (s_last),
        .s_total_length (s_total_length),
        .cmd            (cmd),
        .sts            (sts),
        .m_hash         (m_hash)
    );

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !((cmd.op == OP_FINISH) && m_valid && !m_ready))
        else $error("hash register overwritten while stalled");

    // The core is not ready in the cycle after it takes a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("beat accepted in back-to-back cycles");

    // A new result appears only right after the finishing operation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.op == OP_FINISH))
        else $error("result valid without final mix");

    // A beat without last never starts the final multiply directly.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last) |=> (cmd.op == OP_MIX || cmd.op == OP_XS16))
        else $error("non-last beat skipped its word step");

endmodule

// ===== hdl/mm1h_ctrl.sv =====
// Controller state machine of the MurmurHash1 stream core.
// Depends on mm1h_pkg; drives mm1h_datapath through a command struct.
module mm1h_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_first,
    input  logic                 s_last,
    output logic                 s_ready,
    input  logic                 m_ready,
    output logic                 m_valid,
    input  mm1h_pkg::dp_status_t sts,
    output mm1h_pkg::dp_cmd_t    cmd
);
    import mm1h_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   out_valid_reg, out_valid_next;

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next     = state_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd.op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op    = OP_START;
                    last_next = s_last;
                    // A seeded item with data still owes its word step; a later beat with data
                    // already mixed its word in the start cycle; an empty beat goes to the final mix.
                    if (s_first && sts.word_used) begin
                        state_next = ST_MIX;
                    end else if (sts.word_used) begin
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = ST_FMUL_A;
                    end
                end
            end
            ST_MIX: begin
                cmd.op     = OP_MIX;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.op     = OP_XS16;
                state_next = last_reg ? ST_FMUL_A : ST_IDLE;
            end
            ST_FMUL_A: begin
                cmd.op     = OP_FMUL;
                state_next = ST_FMIX_A;
            end
            ST_FMIX_A: begin
                cmd.op     = OP_XS10;
                state_next = ST_FMUL_B;
            end
            ST_FMUL_B: begin
                cmd.op     = OP_FMUL;
                state_next = ST_FMIX_B;
            end
            ST_FMIX_B: begin
                // Wait until the output register is free.
                if (!out_valid_reg || m_ready) begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== hdl/mm1h_datapath.sv =====
// Datapath of the MurmurHash1 stream core: running hash, shared constant
// multiplier and output register. Depends on mm1h_pkg.
module mm1h_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [31:0]                  s_word,
    input  logic [mm1h_pkg::BCNT_W-1:0]  s_byte_count,
    input  logic                         s_first,
    input  logic                         s_last,
    input  logic [31:0]                  s_total_length,
    input  mm1h_pkg::dp_cmd_t            cmd,
    output mm1h_pkg::dp_status_t         sts,
    output logic [31:0]                  m_hash
);
    import mm1h_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] in_word;
    logic [31:0] mul_a;
    logic [63:0] product_full;
    logic [31:0] product;

    // Only the last beat honors its byte count.
    assign in_word       = s_last ? (s_word & byte_mask(s_byte_count)) : s_word;
    assign sts.word_used = !s_last || (s_byte_count != '0);

    // Operand of the shared multiplier by M.
    always_comb begin
        unique case (cmd.op)
            OP_START: mul_a = s_first ? s_total_length : (acc_reg + in_word);
            OP_MIX:   mul_a = acc_reg + word_reg;
            default:  mul_a = acc_reg;
        endcase
    end

    assign product_full = 64'(mul_a) * 64'(MURMUR_MULT);
    assign product      = product_full[31:0];

    // Running hash update for each operation.
    always_comb begin
        acc_next  = acc_reg;
        word_next = word_reg;
        hash_next = hash_reg;
        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_START: begin
                word_next = in_word;
                if (s_first || sts.word_used) begin
                    acc_next = product;
                end
            end
            OP_MIX, OP_FMUL: begin
                acc_next = product;
            end
            OP_XS16: begin
                acc_next = acc_reg ^ (acc_reg >> MIX_SHIFT);
            end
            OP_XS10: begin
                acc_next = acc_reg ^ (acc_reg >> FINAL_SHIFT_A);
            end
            OP_FINISH: begin
                hash_next = acc_reg ^ (acc_reg >> FINAL_SHIFT_B);
                acc_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // The held word and the result register are only read after being loaded.
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        hash_reg <= hash_next;
    end

    assign m_hash = hash_reg;

    // The running hash restarts from zero after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

endmodule
